@@ src/fgbu_pkg.sv @@
package fgbu_pkg;

  localparam int MAX_GLYPH         = 64;
  localparam int MAX_CELLS_PER_ROW = 256;
  localparam int QUEUE_DEPTH       = 2;

  localparam int SIZE_W  = 7;
  localparam int CPR_W   = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int X_W     = 14;
  localparam int Y_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_PER_ROW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATED       = 3'd5;

  typedef struct packed {
    logic [SIZE_W-1:0] glyph_width;
    logic [SIZE_W-1:0] glyph_height;
    logic [SIZE_W-1:0] cell_width;
    logic [SIZE_W-1:0] cell_height;
    logic [CPR_W-1:0]  cells_per_row;
    logic              rotated;
  } cfg_t;

  typedef struct packed {
    logic [X_W-1:0] base_x;
    logic [Y_W-1:0] base_y;
    logic [5:0]     line;
    logic [5:0]     pstart;
    logic [2:0]     last;
    logic           rotated;
    logic [7:0]     data;
  } desc_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > SIZE_W'(MAX_GLYPH)) begin
      r = SIZE_W'(MAX_GLYPH);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [CPR_W-1:0] clamp_cpr(input logic [CPR_W-1:0] v);
    logic [CPR_W-1:0] r;
    if (v == '0) begin
      r = CPR_W'(1);
    end else if (v > CPR_W'(MAX_CELLS_PER_ROW)) begin
      r = CPR_W'(MAX_CELLS_PER_ROW);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [3:0] bytes_for(input logic [SIZE_W-1:0] v);
    logic [SIZE_W:0] s;
    s = {1'b0, v} + (SIZE_W+1)'(7);
    return 4'(s >> 3);
  endfunction

endpackage

@@ src/fgbu_front.sv @@
module fgbu_front
  import fgbu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       accept,
  input  logic [7:0] font_byte,
  output logic       push,
  output desc_t      desc
);

  logic [2:0] byte_in_line;
  logic [5:0] line_in_glyph;
  logic [7:0] cell_column;
  logic [9:0] cell_row;

  logic [SIZE_W-1:0] gw, gh, cw, chh, cropw, croph, lines, line_lim, pix_lim;
  logic [CPR_W-1:0]  cpr;
  logic [3:0]        bpl;
  logic [5:0]        pstart;
  logic [SIZE_W-1:0] diff;
  logic              emit;
  logic [14:0]       prod_x;
  logic [16:0]       prod_y;
  logic [3:0]        bil_inc;
  logic [6:0]        lig_inc;
  logic [8:0]        cc_inc;

  always_comb begin
    gw    = clamp_size(cfg.glyph_width);
    gh    = clamp_size(cfg.glyph_height);
    cw    = clamp_size(cfg.cell_width);
    chh   = clamp_size(cfg.cell_height);
    cpr   = clamp_cpr(cfg.cells_per_row);
    cropw = (gw < cw) ? gw : cw;
    croph = (gh < chh) ? gh : chh;
    if (cfg.rotated) begin
      lines    = gw;
      bpl      = bytes_for(gh);
      line_lim = cropw;
      pix_lim  = croph;
    end else begin
      lines    = gh;
      bpl      = bytes_for(gw);
      line_lim = croph;
      pix_lim  = cropw;
    end
    pstart = {byte_in_line, 3'b000};
    diff   = pix_lim - {1'b0, pstart};
    emit   = ({1'b0, line_in_glyph} < line_lim) && (pix_lim > {1'b0, pstart});
    prod_x = 15'(cw) * 15'(cell_column);
    prod_y = 17'(chh) * 17'(cell_row);
    bil_inc = {1'b0, byte_in_line} + 4'd1;
    lig_inc = {1'b0, line_in_glyph} + 7'd1;
    cc_inc  = {1'b0, cell_column} + 9'd1;

    push         = accept && emit;
    desc.base_x  = prod_x[X_W-1:0];
    desc.base_y  = prod_y[Y_W-1:0];
    desc.line    = line_in_glyph;
    desc.pstart  = pstart;
    desc.last    = (diff > SIZE_W'(8)) ? 3'd7 : 3'(diff - SIZE_W'(1));
    desc.rotated = cfg.rotated;
    desc.data    = font_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_in_line  <= '0;
      line_in_glyph <= '0;
      cell_column   <= '0;
      cell_row      <= '0;
    end else if (accept) begin
      if (bil_inc >= bpl) begin
        byte_in_line <= '0;
        if (lig_inc >= lines) begin
          line_in_glyph <= '0;
          if (cc_inc >= cpr) begin
            cell_column <= '0;
            cell_row    <= cell_row + 10'd1;
          end else begin
            cell_column <= cc_inc[7:0];
          end
        end else begin
          line_in_glyph <= lig_inc[5:0];
        end
      end else begin
        byte_in_line <= bil_inc[2:0];
      end
    end
  end

endmodule

@@ src/fgbu_queue.sv @@
module fgbu_queue
  import fgbu_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t wr_data,
  input  logic  pop,
  output logic  full,
  output logic  nonempty,
  output desc_t rd_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  desc_t         mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  assign full     = (count == (AW+1)'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ src/fgbu_back.sv @@
module fgbu_back
  import fgbu_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  desc_t          q_data,
  output logic           q_pop,
  output logic           pixel_valid,
  input  logic           pixel_stall,
  output logic [X_W-1:0] pixel_x,
  output logic [Y_W-1:0] pixel_y,
  output logic           ink,
  output logic           run_end
);

  desc_t      cur;
  logic       cur_valid;
  logic [2:0] k;
  logic       out_free, cur_last;
  logic [5:0] p, off_x, off_y;

  always_comb begin
    out_free = !pixel_valid || !pixel_stall;
    cur_last = (k == cur.last);
    q_pop    = q_valid && (!cur_valid || (out_free && cur_last));
    p        = cur.pstart + 6'(k);
    off_x    = cur.rotated ? cur.line : p;
    off_y    = cur.rotated ? p : cur.line;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
      cur_valid   <= 1'b0;
      k           <= '0;
    end else begin
      if (out_free) begin
        pixel_valid <= cur_valid;
      end
      if (q_pop) begin
        k <= '0;
      end else if (out_free && cur_valid) begin
        k <= cur_last ? 3'd0 : k + 3'd1;
      end
      if (q_pop) begin
        cur_valid <= 1'b1;
      end else if (out_free && cur_valid && cur_last) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (out_free && cur_valid) begin
      pixel_x <= cur.base_x + X_W'(off_x);
      pixel_y <= cur.base_y + Y_W'(off_y);
      ink     <= cur.data[3'd7 - k];
      run_end <= cur_last;
    end
  end

endmodule

@@ src/font_glyph_bitmap_unpacker.sv @@
// Expands 1-bit-per-pixel font bytes into pixel requests (x, y, ink) for a
// grid of character cells. A font byte is accepted while the queue is not
// full; the bytes that land in the visible part of a glyph are queued (two
// entries) and expanded at one pixel per cycle through a single output
// register, so a byte yields its visible pixels, up to 8, and bytes with no
// visible pixel are not queued. Sustained rate is one pixel per clock while
// the output is not stalled. run_end marks the last pixel of a byte.
// Configuration registers must be written by the user through cfg_* only
// while idle; the block does not enforce this. cfg_ready is always high.
module font_glyph_bitmap_unpacker
  import fgbu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  font_valid,
  output logic                  font_stall,
  input  logic [7:0]            font_byte,
  output logic                  pixel_valid,
  input  logic                  pixel_stall,
  output logic [X_W-1:0]        pixel_x,
  output logic [Y_W-1:0]        pixel_y,
  output logic                  ink,
  output logic                  run_end
);

  cfg_t  cfg;
  desc_t f_desc, q_desc;
  logic  accept, push, pop, q_full, q_valid;

  assign cfg_ready  = 1'b1;
  assign font_stall = q_full;
  assign accept     = font_valid && !font_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.glyph_width   <= SIZE_W'(8);
      cfg.glyph_height  <= SIZE_W'(8);
      cfg.cell_width    <= SIZE_W'(8);
      cfg.cell_height   <= SIZE_W'(8);
      cfg.cells_per_row <= CPR_W'(16);
      cfg.rotated       <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GLYPH_WIDTH:   cfg.glyph_width   <= cfg_data[SIZE_W-1:0];
        REG_GLYPH_HEIGHT:  cfg.glyph_height  <= cfg_data[SIZE_W-1:0];
        REG_CELL_WIDTH:    cfg.cell_width    <= cfg_data[SIZE_W-1:0];
        REG_CELL_HEIGHT:   cfg.cell_height   <= cfg_data[SIZE_W-1:0];
        REG_CELLS_PER_ROW: cfg.cells_per_row <= cfg_data[CPR_W-1:0];
        REG_ROTATED:       cfg.rotated       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  fgbu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .font_byte (font_byte),
    .push      (push),
    .desc      (f_desc)
  );

  fgbu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_data  (f_desc),
    .pop      (pop),
    .full     (q_full),
    .nonempty (q_valid),
    .rd_data  (q_desc)
  );

  fgbu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (q_desc),
    .q_pop       (pop),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .ink         (ink),
    .run_end     (run_end)
  );

endmodule

@@ src/fgbu_checker.sv @@
module fgbu_checker
  import fgbu_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  font_stall,
  input logic                  pixel_valid,
  input logic                  pixel_stall,
  input logic [X_W-1:0]        pixel_x,
  input logic [Y_W-1:0]        pixel_y,
  input logic                  ink,
  input logic                  run_end
);

  // a stalled pixel request holds
  a_pixel_hold: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel_x) && $stable(pixel_y)
      && $stable(ink) && $stable(run_end))
    else $error("stalled pixel request changed");

  a_reset_out: assert property (@(posedge clk) rst |=> !pixel_valid)
    else $error("pixel request valid after reset");

  a_reset_in: assert property (@(posedge clk) rst |=> !font_stall)
    else $error("input stalled after reset");

  // pixels of one byte come back to back along the line
  a_run_next: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_stall && !run_end |=> pixel_valid
      && ((pixel_x == $past(pixel_x) + X_W'(1)) || (pixel_y == $past(pixel_y) + Y_W'(1))))
    else $error("run broken inside a byte");

endmodule

bind font_glyph_bitmap_unpacker fgbu_checker u_fgbu_checker (.*);

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import fgbu_pkg::*;

  localparam int CELL_ROWS = 1024;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic           ink;
    logic           last;
  } pixel_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  font_valid;
  logic                  font_stall;
  logic [7:0]            font_byte;
  logic                  pixel_valid;
  logic                  pixel_stall;
  logic [X_W-1:0]        pixel_x;
  logic [Y_W-1:0]        pixel_y;
  logic                  ink;
  logic                  run_end;

  font_glyph_bitmap_unpacker dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .font_valid  (font_valid),
    .font_stall  (font_stall),
    .font_byte   (font_byte),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .ink         (ink),
    .run_end     (run_end)
  );

  // configuration copy
  int unsigned gly_w, gly_h, cel_w, cel_h, row_cells, rot;
  // glyph walk counters
  int unsigned byte_pos, line_pos, cell_col, cell_rw;

  logic [7:0] font_feed[$];
  pixel_t     pixel_exp[$];

  bit font_fire;
  int font_gap;
  int stall_left;
  int src_pct;
  int sink_pct;
  int errors;
  int bytes_sent;
  int pixels_seen;
  int cfg_writes;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int unsigned fit(input int unsigned v, input int unsigned hi);
    return (v == 0) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_GLYPH_WIDTH:   gly_w = 32'(val[SIZE_W-1:0]);
      REG_GLYPH_HEIGHT:  gly_h = 32'(val[SIZE_W-1:0]);
      REG_CELL_WIDTH:    cel_w = 32'(val[SIZE_W-1:0]);
      REG_CELL_HEIGHT:   cel_h = 32'(val[SIZE_W-1:0]);
      REG_CELLS_PER_ROW: row_cells = 32'(val[CPR_W-1:0]);
      REG_ROTATED:       rot = 32'(val[0]);
      default: ;
    endcase
  endtask

  task automatic expand_byte(input logic [7:0] b);
    int unsigned gw, gh, cw, ch, cpr, crop_w, crop_h;
    int unsigned lines, per_line, line_lim, pix_lim, first, npix, p, bx, by;
    pixel_t px;
    gw = fit(gly_w, MAX_GLYPH);
    gh = fit(gly_h, MAX_GLYPH);
    cw = fit(cel_w, MAX_GLYPH);
    ch = fit(cel_h, MAX_GLYPH);
    cpr = fit(row_cells, MAX_CELLS_PER_ROW);
    crop_w = (gw < cw) ? gw : cw;
    crop_h = (gh < ch) ? gh : ch;
    bx = cw * cell_col;
    by = ch * cell_rw;
    if (rot != 0) begin
      lines = gw;
      per_line = (gh + 7) / 8;
      line_lim = crop_w;
      pix_lim = crop_h;
    end else begin
      lines = gh;
      per_line = (gw + 7) / 8;
      line_lim = crop_h;
      pix_lim = crop_w;
    end
    first = byte_pos * 8;
    npix = 0;
    if (line_pos < line_lim && pix_lim > first) begin
      npix = pix_lim - first;
      if (npix > 8) npix = 8;
    end
    for (int i = 0; i < npix; i++) begin
      p = first + i;
      px.x = X_W'((rot != 0) ? bx + line_pos : bx + p);
      px.y = Y_W'((rot != 0) ? by + p : by + line_pos);
      px.ink = b[7 - i];
      px.last = (i == npix - 1);
      pixel_exp.push_back(px);
    end
    byte_pos++;
    if (byte_pos >= per_line) begin
      byte_pos = 0;
      line_pos++;
      if (line_pos >= lines) begin
        line_pos = 0;
        cell_col++;
        if (cell_col >= cpr) begin
          cell_col = 0;
          cell_rw = (cell_rw + 1) % CELL_ROWS;
        end
      end
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      font_valid <= 1'b0;
    end else if (!font_valid || font_fire) begin
      if (font_gap > 0) begin
        font_valid <= 1'b0;
        font_gap--;
      end else if (font_feed.size() > 0) begin
        font_byte <= font_feed.pop_front();
        font_valid <= 1'b1;
        font_gap = pick_gap(src_pct);
      end else begin
        font_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      pixel_stall <= 1'b0;
    end else begin
      if (stall_left == 0) stall_left = pick_gap(sink_pct);
      if (stall_left > 0) begin
        pixel_stall <= 1'b1;
        stall_left--;
      end else begin
        pixel_stall <= 1'b0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    pixel_t want;
    font_fire = !rst && font_valid && !font_stall;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
        cfg_writes++;
      end
      if (font_fire) begin
        expand_byte(font_byte);
        bytes_sent++;
      end
      if (pixel_valid && !pixel_stall) begin
        pixels_seen++;
        if (pixel_exp.size() == 0) begin
          errors++;
          if (errors < 20)
            $display("%0t: unexpected pixel x=%0d y=%0d ink=%0b run_end=%0b",
                     $time, pixel_x, pixel_y, ink, run_end);
        end else begin
          want = pixel_exp.pop_front();
          if (pixel_x !== want.x || pixel_y !== want.y || ink !== want.ink ||
              run_end !== want.last) begin
            errors++;
            if (errors < 20)
              $display({"%0t: pixel mismatch exp x=%0d y=%0d ink=%0b run_end=%0b",
                        " got x=%0d y=%0d ink=%0b run_end=%0b"},
                       $time, want.x, want.y, want.ink, want.last,
                       pixel_x, pixel_y, ink, run_end);
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_config(input logic [CFG_DATA_W-1:0] gw, gh, cw, ch, cpr, rt);
    write_reg(REG_GLYPH_WIDTH, gw);
    write_reg(REG_GLYPH_HEIGHT, gh);
    write_reg(REG_CELL_WIDTH, cw);
    write_reg(REG_CELL_HEIGHT, ch);
    write_reg(REG_CELLS_PER_ROW, cpr);
    write_reg(REG_ROTATED, rt);
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                CFG_DATA_W'($urandom_range(0, 511)));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling();
    src_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
    sink_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
  endtask

  // wait until every expected pixel is back and the block has gone quiet
  task automatic drain();
    int guard;
    guard = 0;
    while ((font_feed.size() > 0 || font_valid || pixel_exp.size() > 0) && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (24) @(posedge clk);
  endtask

  task automatic feed_random(input int n);
    repeat (n) font_feed.push_back(8'($urandom_range(0, 255)));
    drain();
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 14) return CFG_DATA_W'($urandom_range(65, 511));
    if (r < 40) return CFG_DATA_W'($urandom_range(1, 8));
    if (r < 48) return CFG_DATA_W'(MAX_GLYPH);
    return CFG_DATA_W'($urandom_range(1, 24));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_cpr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return CFG_DATA_W'($urandom_range(257, 511));
    if (r < 22) return CFG_DATA_W'(MAX_CELLS_PER_ROW);
    return CFG_DATA_W'($urandom_range(1, 6));
  endfunction

  initial begin
    #8000000;
    $display("[font_glyph_bitmap_unpacker] ERROR");
    $finish;
  end

  initial begin
    int n;
    int random_total;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    font_valid = 1'b0;
    font_byte = '0;
    pixel_stall = 1'b0;
    font_fire = 1'b0;
    font_gap = 0;
    stall_left = 0;
    src_pct = 0;
    sink_pct = 0;
    errors = 0;
    bytes_sent = 0;
    pixels_seen = 0;
    cfg_writes = 0;
    gly_w = 8;
    gly_h = 8;
    cel_w = 8;
    cel_h = 8;
    row_cells = 16;
    rot = 0;
    byte_pos = 0;
    line_pos = 0;
    cell_col = 0;
    cell_rw = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset geometry, plain 8x8
    font_feed = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55};
    drain();
    // zero sizes act as one
    load_config('0, '0, '0, '0, '0, '0);
    font_feed = '{8'hFF, 8'h7F, 8'h80};
    drain();
    // oversize values clamp to the maximum
    load_config(9'd127, 9'd127, 9'd127, 9'd127, 9'd511, 9'd0);
    font_feed = '{8'hC3, 8'h3C, 8'hFF};
    drain();
    // crop: bytes past the crop width and cropped lines
    load_config(9'd16, 9'd4, 9'd5, 9'd2, 9'd3, 9'd0);
    font_feed = '{8'hF8, 8'hFF, 8'h0F, 8'hFF, 8'hFF, 8'hFF};
    drain();
    // rotated crop
    load_config(9'd4, 9'd12, 9'd3, 9'd9, 9'd2, 9'd1);
    font_feed = '{8'hA5, 8'h80, 8'h5A, 8'h7F, 8'hFF, 8'hFF};
    drain();

    set_idling();
    load_config(9'd64, 9'd64, 9'd64, 9'd64, 9'd256, 9'd0);
    feed_random(60);
    set_idling();
    load_config(9'd1, 9'd1, 9'd1, 9'd1, 9'd1, 9'd1);
    feed_random(20);
    // one byte per cell row, tall cells
    set_idling();
    load_config(9'd1, 9'd1, CFG_DATA_W'($urandom_range(1, 64)), 9'd64, 9'd1,
                CFG_DATA_W'($urandom_range(0, 1)));
    feed_random(40);

    random_total = 0;
    while (random_total < 290) begin
      n = $urandom_range(20, 50);
      set_idling();
      load_config(pick_size(), pick_size(), pick_size(), pick_size(), pick_cpr(),
                  CFG_DATA_W'($urandom_range(0, 511)));
      feed_random(n);
      random_total += n;
    end

    drain();
    if (pixel_exp.size() != 0) begin
      $display("%0t: %0d expected pixels never arrived", $time, pixel_exp.size());
      errors++;
    end
    $display("font bytes sent %0d, pixels checked %0d, register writes %0d",
             bytes_sent, pixels_seen, cfg_writes);
    $display("covered crop, rotation, zero and oversize registers, one-byte cells");
    if (errors == 0) begin
      $display("[font_glyph_bitmap_unpacker] OK");
    end else begin
      $display("[font_glyph_bitmap_unpacker] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/fgbu_pkg.sv
src/fgbu_front.sv
src/fgbu_queue.sv
src/fgbu_back.sv
src/font_glyph_bitmap_unpacker.sv
src/fgbu_checker.sv
tb/tb.sv
